@@ design/hsv565_pkg.sv @@
// Shared types and constants for the HSV to RGB565 converter.
// No dependencies; the top level and its checker use it.
package hsv565_pkg;

    // Field widths.
    localparam int HUE_W   = 12;
    localparam int BYTE_W  = 8;
    localparam int DEG_W   = 9;
    localparam int REM_W   = 6;
    localparam int SPAN_W  = 14;
    localparam int NUM_W   = 22;
    localparam int PNUM_W  = 16;
    localparam int PIXEL_W = 16;
    localparam int IN_W    = 32;

    // Geometry of the hue circle.
    localparam int CIRCLE_DEG = 360;
    localparam int SECTOR_DEG = 60;
    localparam int MAX_WRAPS  = ((1 << HUE_W) - 1) / CIRCLE_DEG;
    localparam int SECTORS    = CIRCLE_DEG / SECTOR_DEG;

    // Divisors and their truncated reciprocals.
    localparam int FULL_SCALE = 255;
    localparam int FRAC_SCALE = FULL_SCALE * SECTOR_DEG;
    localparam int SHIFT_Q    = 32;
    localparam longint RECIP_Q = (64'd1 << SHIFT_Q) / FRAC_SCALE;
    localparam int RECIP_Q_W  = 19;
    localparam int SHIFT_P    = 16;
    localparam int RECIP_P    = (1 << SHIFT_P) / FULL_SCALE;
    localparam int RECIP_P_W  = 9;
    localparam int PROD_Q_W   = NUM_W + RECIP_Q_W;
    localparam int PROD_P_W   = PNUM_W + RECIP_P_W;
    localparam int RQ_W       = 15;
    localparam int RP_W       = 9;

    // Pipeline depth from input register to output register.
    localparam int STAGES = 7;

    // Color wheel sectors, 60 degrees each.
    typedef enum logic [2:0] {
        SEC_RED_YEL  = 3'd0,
        SEC_YEL_GRN  = 3'd1,
        SEC_GRN_CYAN = 3'd2,
        SEC_CYAN_BLU = 3'd3,
        SEC_BLU_MAG  = 3'd4,
        SEC_MAG_RED  = 3'd5
    } t_sector;

endpackage

@@ design/hsv_to_rgb565_converter_unit.sv @@
// Top level of the HSV to RGB565 converter: a seven-stage pipeline.
// Depends on hsv565_pkg.
//
// An accepted input item passes through the stage registers 1 to 7 in order to become its result item.
// Throughput: one item per cycle while the output is not stalled; the stage chain with a multiplier per lane sets this.
// Each stage holds its item while the stage after it is full and not moving,
// so a bubble anywhere is filled and a stall loses nothing.
// Reset (synchronous, active low) clears all stage valid bits; data registers keep values.
module hsv_to_rgb565_converter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // hue [11:0], saturation [19:12], value [27:20], zero [31:28]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // pixel [15:0]
);

    localparam int N = hsv565_pkg::STAGES;

    // Per-stage valid bits and the ready chain running back from the output.
    logic [N:1]   r_vld;
    logic [N+1:1] w_rdy;

    always_comb begin
        w_rdy[N+1] = i_m_tready;
        for (int k = N; k >= 1; k--) begin
            w_rdy[k] = !r_vld[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= N; k++) begin
                if (w_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_s_tready = w_rdy[1];
    assign o_m_tvalid = r_vld[N];

    // Unpack the input item.
    logic [hsv565_pkg::HUE_W-1:0]  w_hue;
    logic [hsv565_pkg::BYTE_W-1:0] w_sat;
    logic [hsv565_pkg::BYTE_W-1:0] w_val;

    assign w_hue = i_s_tdata[11:0];
    assign w_sat = i_s_tdata[19:12];
    assign w_val = i_s_tdata[27:20];

    // Stage 1: reduce the hue modulo 360 by comparing it against every multiple
    // of the full circle that a 12-bit hue can reach.
    logic [hsv565_pkg::DEG_W-1:0]  n_s1_deg;
    logic [hsv565_pkg::DEG_W-1:0]  r_s1_deg;
    logic [hsv565_pkg::BYTE_W-1:0] r_s1_sat;
    logic [hsv565_pkg::BYTE_W-1:0] r_s1_val;

    always_comb begin
        n_s1_deg = w_hue[hsv565_pkg::DEG_W-1:0];
        for (int i = 1; i <= hsv565_pkg::MAX_WRAPS; i++) begin
            if (w_hue >= hsv565_pkg::HUE_W'(hsv565_pkg::CIRCLE_DEG * i)) begin
                n_s1_deg = hsv565_pkg::DEG_W'(w_hue -
                           hsv565_pkg::HUE_W'(hsv565_pkg::CIRCLE_DEG * i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r_s1_deg <= n_s1_deg;
            r_s1_sat <= w_sat;
            r_s1_val <= w_val;
        end
    end

    // Stage 2: split the angle into a sector and the remainder within it.
    hsv565_pkg::t_sector           n_s2_sec;
    logic [hsv565_pkg::REM_W-1:0]  n_s2_rem;
    hsv565_pkg::t_sector           r_s2_sec;
    logic [hsv565_pkg::REM_W-1:0]  r_s2_rem;
    logic [hsv565_pkg::BYTE_W-1:0] r_s2_sat;
    logic [hsv565_pkg::BYTE_W-1:0] r_s2_val;

    always_comb begin
        n_s2_sec = hsv565_pkg::SEC_RED_YEL;
        n_s2_rem = r_s1_deg[hsv565_pkg::REM_W-1:0];
        for (int i = 1; i < hsv565_pkg::SECTORS; i++) begin
            if (r_s1_deg >= hsv565_pkg::DEG_W'(hsv565_pkg::SECTOR_DEG * i)) begin
                n_s2_sec = hsv565_pkg::t_sector'(3'(i));
                n_s2_rem = hsv565_pkg::REM_W'(r_s1_deg -
                           hsv565_pkg::DEG_W'(hsv565_pkg::SECTOR_DEG * i));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r_s2_sec <= n_s2_sec;
            r_s2_rem <= n_s2_rem;
            r_s2_sat <= r_s1_sat;
            r_s2_val <= r_s1_val;
        end
    end

    // Stage 3: saturation scaled by the falling and rising parts of the sector,
    // and the complement of saturation for the floor level.
    logic [hsv565_pkg::SPAN_W-1:0] r_s3_fall;
    logic [hsv565_pkg::SPAN_W-1:0] r_s3_rise;
    logic [hsv565_pkg::BYTE_W-1:0] r_s3_csat;
    hsv565_pkg::t_sector           r_s3_sec;
    logic [hsv565_pkg::BYTE_W-1:0] r_s3_val;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r_s3_fall <= hsv565_pkg::SPAN_W'(r_s2_sat) * hsv565_pkg::SPAN_W'(r_s2_rem);
            r_s3_rise <= hsv565_pkg::SPAN_W'(r_s2_sat) *
                         hsv565_pkg::SPAN_W'(hsv565_pkg::REM_W'(hsv565_pkg::SECTOR_DEG) -
                                             r_s2_rem);
            r_s3_csat <= hsv565_pkg::BYTE_W'(hsv565_pkg::FULL_SCALE) - r_s2_sat;
            r_s3_sec  <= r_s2_sec;
            r_s3_val  <= r_s2_val;
        end
    end

    // Stage 4: numerators of q, t and p, one multiplier per lane.
    logic [hsv565_pkg::NUM_W-1:0]  r_s4_nq;
    logic [hsv565_pkg::NUM_W-1:0]  r_s4_nt;
    logic [hsv565_pkg::PNUM_W-1:0] r_s4_np;
    hsv565_pkg::t_sector           r_s4_sec;
    logic [hsv565_pkg::BYTE_W-1:0] r_s4_val;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r_s4_nq  <= hsv565_pkg::NUM_W'(r_s3_val) *
                        hsv565_pkg::NUM_W'(hsv565_pkg::SPAN_W'(hsv565_pkg::FRAC_SCALE) - r_s3_fall);
            r_s4_nt  <= hsv565_pkg::NUM_W'(r_s3_val) *
                        hsv565_pkg::NUM_W'(hsv565_pkg::SPAN_W'(hsv565_pkg::FRAC_SCALE) - r_s3_rise);
            r_s4_np  <= hsv565_pkg::PNUM_W'(r_s3_val) * hsv565_pkg::PNUM_W'(r_s3_csat);
            r_s4_sec <= r_s3_sec;
            r_s4_val <= r_s3_val;
        end
    end

    // Stage 5: quotient estimates by multiplying with truncated reciprocals.
    // The estimate is the true quotient or one less.
    logic [hsv565_pkg::PROD_Q_W-1:0] w_prod_q;
    logic [hsv565_pkg::PROD_Q_W-1:0] w_prod_t;
    logic [hsv565_pkg::PROD_P_W-1:0] w_prod_p;
    logic [hsv565_pkg::BYTE_W-1:0]   r_s5_eq;
    logic [hsv565_pkg::BYTE_W-1:0]   r_s5_et;
    logic [hsv565_pkg::BYTE_W-1:0]   r_s5_ep;
    logic [hsv565_pkg::NUM_W-1:0]    r_s5_nq;
    logic [hsv565_pkg::NUM_W-1:0]    r_s5_nt;
    logic [hsv565_pkg::PNUM_W-1:0]   r_s5_np;
    hsv565_pkg::t_sector             r_s5_sec;
    logic [hsv565_pkg::BYTE_W-1:0]   r_s5_val;

    assign w_prod_q = hsv565_pkg::PROD_Q_W'(r_s4_nq) *
                      hsv565_pkg::PROD_Q_W'(hsv565_pkg::RECIP_Q);
    assign w_prod_t = hsv565_pkg::PROD_Q_W'(r_s4_nt) *
                      hsv565_pkg::PROD_Q_W'(hsv565_pkg::RECIP_Q);
    assign w_prod_p = hsv565_pkg::PROD_P_W'(r_s4_np) *
                      hsv565_pkg::PROD_P_W'(hsv565_pkg::RECIP_P);

    always_ff @(posedge i_clk) begin
        if (w_rdy[5]) begin
            r_s5_eq  <= w_prod_q[hsv565_pkg::SHIFT_Q +: hsv565_pkg::BYTE_W];
            r_s5_et  <= w_prod_t[hsv565_pkg::SHIFT_Q +: hsv565_pkg::BYTE_W];
            r_s5_ep  <= w_prod_p[hsv565_pkg::SHIFT_P +: hsv565_pkg::BYTE_W];
            r_s5_nq  <= r_s4_nq;
            r_s5_nt  <= r_s4_nt;
            r_s5_np  <= r_s4_np;
            r_s5_sec <= r_s4_sec;
            r_s5_val <= r_s4_val;
        end
    end

    // Stage 6: remainders left by the estimates; each is below twice its divisor.
    logic [hsv565_pkg::NUM_W-1:0]  w_diff_q;
    logic [hsv565_pkg::NUM_W-1:0]  w_diff_t;
    logic [hsv565_pkg::PNUM_W-1:0] w_diff_p;
    logic [hsv565_pkg::RQ_W-1:0]   r_s6_rq;
    logic [hsv565_pkg::RQ_W-1:0]   r_s6_rt;
    logic [hsv565_pkg::RP_W-1:0]   r_s6_rp;
    logic [hsv565_pkg::BYTE_W-1:0] r_s6_eq;
    logic [hsv565_pkg::BYTE_W-1:0] r_s6_et;
    logic [hsv565_pkg::BYTE_W-1:0] r_s6_ep;
    hsv565_pkg::t_sector           r_s6_sec;
    logic [hsv565_pkg::BYTE_W-1:0] r_s6_val;

    assign w_diff_q = r_s5_nq - hsv565_pkg::NUM_W'(r_s5_eq) *
                      hsv565_pkg::NUM_W'(hsv565_pkg::FRAC_SCALE);
    assign w_diff_t = r_s5_nt - hsv565_pkg::NUM_W'(r_s5_et) *
                      hsv565_pkg::NUM_W'(hsv565_pkg::FRAC_SCALE);
    assign w_diff_p = r_s5_np - hsv565_pkg::PNUM_W'(r_s5_ep) *
                      hsv565_pkg::PNUM_W'(hsv565_pkg::FULL_SCALE);

    always_ff @(posedge i_clk) begin
        if (w_rdy[6]) begin
            r_s6_rq  <= w_diff_q[hsv565_pkg::RQ_W-1:0];
            r_s6_rt  <= w_diff_t[hsv565_pkg::RQ_W-1:0];
            r_s6_rp  <= w_diff_p[hsv565_pkg::RP_W-1:0];
            r_s6_eq  <= r_s5_eq;
            r_s6_et  <= r_s5_et;
            r_s6_ep  <= r_s5_ep;
            r_s6_sec <= r_s5_sec;
            r_s6_val <= r_s5_val;
        end
    end

    // Stage 7: correct the quotients, route the levels by sector and pack
    // the top 5, 6 and 5 bits of red, green and blue.
    logic [hsv565_pkg::BYTE_W-1:0]  w_q;
    logic [hsv565_pkg::BYTE_W-1:0]  w_t;
    logic [hsv565_pkg::BYTE_W-1:0]  w_p;
    logic [hsv565_pkg::BYTE_W-1:0]  w_red;
    logic [hsv565_pkg::BYTE_W-1:0]  w_grn;
    logic [hsv565_pkg::BYTE_W-1:0]  w_blu;
    logic [hsv565_pkg::PIXEL_W-1:0] r_s7_pixel;

    assign w_q = r_s6_eq + hsv565_pkg::BYTE_W'(r_s6_rq >= hsv565_pkg::RQ_W'(hsv565_pkg::FRAC_SCALE));
    assign w_t = r_s6_et + hsv565_pkg::BYTE_W'(r_s6_rt >= hsv565_pkg::RQ_W'(hsv565_pkg::FRAC_SCALE));
    assign w_p = r_s6_ep + hsv565_pkg::BYTE_W'(r_s6_rp >= hsv565_pkg::RP_W'(hsv565_pkg::FULL_SCALE));

    always_comb begin
        unique case (r_s6_sec)
            hsv565_pkg::SEC_RED_YEL: begin
                w_red = r_s6_val; w_grn = w_t;      w_blu = w_p;
            end
            hsv565_pkg::SEC_YEL_GRN: begin
                w_red = w_q;      w_grn = r_s6_val; w_blu = w_p;
            end
            hsv565_pkg::SEC_GRN_CYAN: begin
                w_red = w_p;      w_grn = r_s6_val; w_blu = w_t;
            end
            hsv565_pkg::SEC_CYAN_BLU: begin
                w_red = w_p;      w_grn = w_q;      w_blu = r_s6_val;
            end
            hsv565_pkg::SEC_BLU_MAG: begin
                w_red = w_t;      w_grn = w_p;      w_blu = r_s6_val;
            end
            default: begin
                w_red = r_s6_val; w_grn = w_p;      w_blu = w_q;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[7]) begin
            r_s7_pixel <= {w_red[7:3], w_grn[7:2], w_blu[7:3]};
        end
    end

    assign o_m_tdata = r_s7_pixel;

endmodule

@@ design/hsv565_chk.sv @@
// Port-level checker for the HSV to RGB565 converter, with its bind.
// Depends on hsv565_pkg and hsv_to_rgb565_converter_unit.
module hsv565_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);

    // A result that waits keeps its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset empties the pipeline.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // With the output register empty, every stage can move, so input is taken.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled while output empty");

    // With the consumer ready throughout, a black item accepted while the output is empty
    // comes out as black once it has passed through every stage.
    a_black: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready && i_s_tdata[27:20] == 8'd0 &&
        !o_m_tvalid && i_m_tready ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready
        ##1 i_m_tready ##1 i_m_tready ##1 i_m_tready
        |-> ##1 o_m_tvalid && o_m_tdata == hsv565_pkg::PIXEL_W'(0))
        else $error("zero value did not give black");

endmodule

bind hsv_to_rgb565_converter_unit hsv565_chk u_hsv565_chk (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
